FILE: hdl/irpd_pkg.sv
// Package for the IR remote pulse decoder: constants, register indexes and shared types.
`timescale 1ns / 1ps

package irpd_pkg;

  localparam int TIME_W       = 32;
  localparam int BYTE_W       = 8;
  localparam int EDGE_IDX_W   = 7;
  localparam int CFG_INDEX_W  = 3;

  localparam int EDGES_PER_FRAME_DEF = 68;
  localparam int DATA_BITS_DEF       = 32;

  localparam logic [TIME_W-1:0] LEADER_LOW_MIN_RST  = 32'd8000000;
  localparam logic [TIME_W-1:0] LEADER_LOW_MAX_RST  = 32'd10000000;
  localparam logic [TIME_W-1:0] LEADER_HIGH_MIN_RST = 32'd3500000;
  localparam logic [TIME_W-1:0] LEADER_HIGH_MAX_RST = 32'd5500000;
  localparam logic [TIME_W-1:0] ONE_THRESHOLD_RST   = 32'd1000000;
  localparam logic [TIME_W-1:0] FRAME_TIMEOUT_RST   = 32'd100000000;

  localparam logic [BYTE_W-1:0] ERR_BYTE = 8'hFF;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_LEADER_LOW_MIN  = 3'd0,
    REG_LEADER_LOW_MAX  = 3'd1,
    REG_LEADER_HIGH_MIN = 3'd2,
    REG_LEADER_HIGH_MAX = 3'd3,
    REG_ONE_THRESHOLD   = 3'd4,
    REG_FRAME_TIMEOUT   = 3'd5
  } reg_index_t;

  typedef enum logic {
    OP_EDGE  = 1'b0,
    OP_CHECK = 1'b1
  } op_t;

  typedef struct packed {
    logic [TIME_W-1:0] leader_low_min;
    logic [TIME_W-1:0] leader_low_max;
    logic [TIME_W-1:0] leader_high_min;
    logic [TIME_W-1:0] leader_high_max;
    logic [TIME_W-1:0] one_threshold;
    logic [TIME_W-1:0] frame_timeout;
  } cfg_t;

  typedef struct packed {
    logic [BYTE_W-1:0] address;
    logic [BYTE_W-1:0] command;
    logic              error;
  } res_t;

endpackage

FILE: hdl/irpd_if.sv
// Channel interfaces of the IR remote pulse decoder: input words and result words.
`timescale 1ns / 1ps

interface irpd_item_if;
  logic        valid;
  logic        ready;
  logic        op;
  logic [31:0] now_time;

  modport source (output valid, output op, output now_time, input ready);
  modport sink (input valid, input op, input now_time, output ready);
endinterface

interface irpd_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] address;
  logic [7:0] command;
  logic       error;

  modport source (output valid, output address, output command, output error, input ready);
  modport sink (input valid, input address, input command, input error, output ready);
endinterface

FILE: hdl/irpd_cfg_regs.sv
// Configuration register bank of the IR remote pulse decoder.
`timescale 1ns / 1ps

module irpd_cfg_regs (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             wr_en,
  input  logic [irpd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [irpd_pkg::TIME_W-1:0]      wr_data,
  output irpd_pkg::cfg_t                   cfg
);
  import irpd_pkg::*;

  cfg_t regs;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.leader_low_min  <= LEADER_LOW_MIN_RST;
      regs.leader_low_max  <= LEADER_LOW_MAX_RST;
      regs.leader_high_min <= LEADER_HIGH_MIN_RST;
      regs.leader_high_max <= LEADER_HIGH_MAX_RST;
      regs.one_threshold   <= ONE_THRESHOLD_RST;
      regs.frame_timeout   <= FRAME_TIMEOUT_RST;
    end else if (wr_en) begin
      case (reg_index_t'(wr_index))
        REG_LEADER_LOW_MIN:  regs.leader_low_min  <= wr_data;
        REG_LEADER_LOW_MAX:  regs.leader_low_max  <= wr_data;
        REG_LEADER_HIGH_MIN: regs.leader_high_min <= wr_data;
        REG_LEADER_HIGH_MAX: regs.leader_high_max <= wr_data;
        REG_ONE_THRESHOLD:   regs.one_threshold   <= wr_data;
        REG_FRAME_TIMEOUT:   regs.frame_timeout   <= wr_data;
        default: begin
        end
      endcase
    end
  end

  assign cfg = regs;

endmodule

FILE: hdl/irpd_frame_core.sv
// Input register and frame decoding state of the IR remote pulse decoder.
`timescale 1ns / 1ps

module irpd_frame_core #(
  parameter int EDGES_PER_FRAME = irpd_pkg::EDGES_PER_FRAME_DEF,
  parameter int DATA_BITS       = irpd_pkg::DATA_BITS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  irpd_pkg::cfg_t cfg,
  irpd_item_if.sink      item,
  input  logic           out_free,
  output logic           res_valid,
  output irpd_pkg::res_t res
);
  import irpd_pkg::*;

  localparam logic [EDGE_IDX_W-1:0] LastCount = EDGE_IDX_W'(EDGES_PER_FRAME);
  localparam logic [EDGE_IDX_W-1:0] DataBitsW = EDGE_IDX_W'(DATA_BITS);

  logic                  in_valid;
  logic                  in_op;
  logic [TIME_W-1:0]     in_time;

  logic [EDGE_IDX_W-1:0] edge_index;
  logic [EDGE_IDX_W-1:0] edge_index_next;
  logic [TIME_W-1:0]     prev_time;
  logic [TIME_W-1:0]     prev_time_next;
  logic                  leader_bad;
  logic                  leader_bad_next;
  logic [DATA_BITS-1:0]  frame_bits;
  logic [DATA_BITS-1:0]  frame_bits_next;
  logic                  armed;
  logic                  armed_next;

  logic                  step;
  logic [TIME_W-1:0]     delta;
  logic [EDGE_IDX_W-1:0] k_off;
  logic [EDGE_IDX_W-1:0] bit_pos;
  logic [EDGE_IDX_W-1:0] k_inc;
  logic                  data_edge;
  logic [DATA_BITS-1:0]  frame_shift;
  logic [TIME_W-1:0]     frame_word;
  logic [BYTE_W-1:0]     b0;
  logic [BYTE_W-1:0]     b1;
  logic [BYTE_W-1:0]     b2;
  logic [BYTE_W-1:0]     b3;

  assign step       = in_valid && out_free;
  assign item.ready = !in_valid || out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (item.ready) begin
      in_valid <= item.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item.ready && item.valid) begin
      in_op   <= item.op;
      in_time <= item.now_time;
    end
  end

  assign delta       = in_time - prev_time;
  assign k_off       = edge_index - EDGE_IDX_W'(4);
  assign bit_pos     = {1'b0, k_off[EDGE_IDX_W-1:1]};
  assign k_inc       = edge_index + EDGE_IDX_W'(1);
  assign data_edge   = (edge_index >= EDGE_IDX_W'(4)) && !edge_index[0] && (bit_pos < DataBitsW);
  assign frame_shift = data_edge ? {frame_bits[DATA_BITS-2:0], (delta > cfg.one_threshold)}
                                 : frame_bits;
  assign frame_word  = TIME_W'(frame_shift);
  assign b0          = frame_word[31:24];
  assign b1          = frame_word[23:16];
  assign b2          = frame_word[15:8];
  assign b3          = frame_word[7:0];

  always_comb begin
    edge_index_next = edge_index;
    prev_time_next  = prev_time;
    leader_bad_next = leader_bad;
    frame_bits_next = frame_bits;
    armed_next      = armed;
    res_valid       = 1'b0;
    res.address     = ERR_BYTE;
    res.command     = ERR_BYTE;
    res.error       = 1'b1;

    if (op_t'(in_op) == OP_CHECK) begin
      if (step && armed && (delta >= cfg.frame_timeout)) begin
        edge_index_next = '0;
        leader_bad_next = 1'b0;
        frame_bits_next = '0;
        armed_next      = 1'b0;
        res_valid       = 1'b1;
      end
    end else begin
      if (edge_index == EDGE_IDX_W'(0)) begin
        leader_bad_next = 1'b0;
        frame_bits_next = '0;
      end else if (edge_index == EDGE_IDX_W'(1)) begin
        if ((delta < cfg.leader_low_min) || (delta > cfg.leader_low_max)) begin
          leader_bad_next = 1'b1;
        end
      end else if (edge_index == EDGE_IDX_W'(2)) begin
        if ((delta < cfg.leader_high_min) || (delta > cfg.leader_high_max)) begin
          leader_bad_next = 1'b1;
        end
      end else if (data_edge) begin
        frame_bits_next = frame_shift;
      end

      prev_time_next = in_time;

      if (k_inc == LastCount) begin
        if (!leader_bad_next && (b1 == ~b0) && (b3 == ~b2)) begin
          res.address = b0;
          res.command = b2;
          res.error   = 1'b0;
        end
        edge_index_next = '0;
        leader_bad_next = 1'b0;
        frame_bits_next = '0;
        armed_next      = 1'b0;
        res_valid       = step;
      end else begin
        edge_index_next = k_inc;
        armed_next      = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      edge_index <= '0;
      prev_time  <= '0;
      leader_bad <= 1'b0;
      frame_bits <= '0;
      armed      <= 1'b0;
    end else if (step) begin
      edge_index <= edge_index_next;
      prev_time  <= prev_time_next;
      leader_bad <= leader_bad_next;
      frame_bits <= frame_bits_next;
      armed      <= armed_next;
    end
  end

endmodule

FILE: hdl/irpd_out_reg.sv
// Result register of the IR remote pulse decoder, holding one word until it is taken.
`timescale 1ns / 1ps

module irpd_out_reg (
  input  logic           clk,
  input  logic           rst,
  input  logic           res_valid,
  input  irpd_pkg::res_t res,
  output logic           free,
  irpd_result_if.source  result
);
  import irpd_pkg::*;

  logic valid;
  res_t held;

  assign free = !valid || result.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (res_valid) begin
      valid <= 1'b1;
    end else if (result.ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      held <= res;
    end
  end

  assign result.valid   = valid;
  assign result.address = held.address;
  assign result.command = held.command;
  assign result.error   = held.error;

endmodule

FILE: hdl/ir_remote_pulse_decoder_unit.sv
// Top level of the IR remote pulse decoder: configuration bank, frame core and result register.
//
//   Port      Direction  Word
//   item      in         op, now_time (edge timestamp or time check)
//   result    out        address, command, error
//   wr_*      in         register write: wr_en, wr_index, wr_data
//
// One word is taken in every cycle while results are being taken.
// A result is decoded from the input register, then registered in the result register.
// Each word is decoded combinationally from the input register against the frame state.
// Synchronous reset clears the frame state and loads the register defaults.
// While the result register holds a word that has not been taken, the input register stalls.
`timescale 1ns / 1ps

module ir_remote_pulse_decoder_unit #(
  parameter int EDGES_PER_FRAME = irpd_pkg::EDGES_PER_FRAME_DEF,
  parameter int DATA_BITS       = irpd_pkg::DATA_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  irpd_item_if.sink                        item,
  irpd_result_if.source                    result,
  input  logic                             wr_en,
  input  logic [irpd_pkg::CFG_INDEX_W-1:0] wr_index,
  input  logic [irpd_pkg::TIME_W-1:0]      wr_data
);
  import irpd_pkg::*;

  cfg_t cfg;
  res_t res;
  logic res_valid;
  logic out_free;

  irpd_cfg_regs u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data),
    .cfg      (cfg)
  );

  irpd_frame_core #(
    .EDGES_PER_FRAME (EDGES_PER_FRAME),
    .DATA_BITS       (DATA_BITS)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .item      (item),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res)
  );

  irpd_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid),
    .res       (res),
    .free      (out_free),
    .result    (result)
  );

endmodule
